FILE: src/jpvc_pkg.sv
// ----------------------------------------------------------------------------
// jpvc_pkg
// Types, widths and constants shared by the joint pd velocity command block.
// ----------------------------------------------------------------------------
package jpvc_pkg;

    localparam int JOINT_COUNT     = 6;
    localparam int ANGLE_FRAC_BITS = 16;

    localparam int JOINT_W = 3;
    localparam int ANG_W   = 24;
    localparam int GAIN_W  = 24;
    localparam int LIM_W   = 23;
    localparam int SUM_W   = 27;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_TOL  = 2'd3;

    localparam logic [LIM_W-1:0] DRIVE_LIMIT_RST = 23'd12800;
    localparam logic [LIM_W-1:0] FINISH_TOL_RST  = 23'd1966;

    localparam logic [JOINT_W-1:0] POS_JOINT = 3'd1;

    // one turn at the angle scale, 2*pi rounded to nearest
    localparam longint TWO_PI_Q32 = 64'sd26986075409;
    localparam longint TURN =
        (TWO_PI_Q32 + (longint'(1) << (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
    localparam int TURN_W = $clog2(TURN + 1);

    // reciprocal of a turn for the quotient estimate
    localparam int     RECIP_SH = ANG_W;
    localparam longint RECIP    = ((longint'(1) << RECIP_SH) + TURN / 2) / TURN;
    localparam int     RECIP_W  = $clog2(RECIP + 1) + 1;
    localparam int     PROD_W   = ANG_W + RECIP_W;
    localparam int     QUO_W    = PROD_W - RECIP_SH;
    localparam int     MODX_W   = ((QUO_W + TURN_W) > ANG_W ? (QUO_W + TURN_W) : ANG_W) + 1;
    localparam int     RR_W     = TURN_W + 2;
    localparam int     ERR_X_W  = ((RR_W + 1) > (ANG_W + 1)) ? (RR_W + 1) : (ANG_W + 1);

    // drive datapath
    localparam int DIFF_W = ANG_W + 1;
    localparam int PP_W   = GAIN_W + 1 + ANG_W;
    localparam int PD_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = PD_W + 1;
    localparam int DRV_SH = ANGLE_FRAC_BITS + 8;
    localparam int SHF_W  = ACC_W - DRV_SH;
    localparam int NEG_W  = ((SHF_W > ANG_W) ? SHF_W : ANG_W) + 1;
    localparam int SAT_W  = (ERR_X_W > NEG_W) ? ERR_X_W : NEG_W;

    localparam int JIDX_W    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int JCNT_W    = $clog2(JOINT_COUNT + 1);
    localparam int JOINT_X_W = (JCNT_W > JOINT_W) ? JCNT_W : JOINT_W;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint;
        logic signed [ANG_W-1:0] desired_angle;
        logic signed [ANG_W-1:0] measured_angle;
        logic                    restart;
        logic                    at_end;
    } t_in_req;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint_out;
        logic signed [ANG_W-1:0] drive;
        logic                    over_limit;
        logic signed [ANG_W-1:0] joint_error;
        logic                    done_res;
    } t_out_res;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic               restart;
        logic               at_end;
    } t_ctrl;

    typedef struct packed {
        t_ctrl                   ctrl;
        logic signed [ANG_W-1:0] err;
    } t_err_item;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((longint'(1) << (ANG_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SAT_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[ANG_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[ANG_W-1:0];
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/jpvc_err_pipe.sv
// ----------------------------------------------------------------------------
// jpvc_err_pipe
// Wraps the desired angle to one turn, picks the turn copy nearest the
// measured angle; the saturated position error leaves one per unstalled cycle.
// ----------------------------------------------------------------------------
module jpvc_err_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jpvc_pkg::t_in_req   i_in_req,
    output logic                o_err_valid,
    input  logic                i_err_ready,
    output jpvc_pkg::t_err_item o_err_item
);
    import jpvc_pkg::*;

    localparam logic signed [RECIP_W-1:0] RECIP_S  = RECIP_W'(RECIP);
    localparam logic signed [MODX_W-1:0]  TURN_M   = MODX_W'(TURN);
    localparam logic signed [RR_W-1:0]    TURN_R   = RR_W'(TURN);
    localparam logic signed [RR_W-1:0]    TURN2_R  = RR_W'(2 * TURN);
    localparam logic signed [ERR_X_W-1:0] TURN_E   = ERR_X_W'(TURN);
    localparam logic signed [ANG_W-1:0]   ERR_BND  = ANG_W'(TURN / 2 + 1);

    logic en1, en2, en3, en4, en5;
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    t_in_req                  r_s1_req;
    t_ctrl                    r_s2_ctrl, r_s3_ctrl, r_s4_ctrl;
    logic signed [ANG_W-1:0]  r_s2_des, r_s2_meas;
    logic signed [QUO_W-1:0]  r_s2_qd, r_s2_qm, n_s2_qd, n_s2_qm;
    logic signed [RR_W-1:0]   r_s3_rrd, r_s3_rrm, n_s3_rrd, n_s3_rrm;
    logic signed [RR_W-1:0]   r_s4_s, r_s4_rm, n_s4_s, n_s4_rm;
    t_err_item                r_s5_item;
    logic signed [ANG_W-1:0]  n_s5_err;

    logic signed [PROD_W-1:0]  prod_d, prod_m;
    logic signed [MODX_W-1:0]  mod_d, mod_m;
    logic signed [RR_W-1:0]    rd_fix;
    logic signed [ERR_X_W-1:0] s_x, rm_x, d_x, e_x;

    function automatic logic signed [RR_W-1:0] mod_fix(input logic signed [RR_W-1:0] v);
        logic signed [RR_W-1:0] r;
        if (v < 0) begin
            r = v + TURN_R;
        end else if (v >= TURN_R) begin
            r = v - TURN_R;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign en5 = !r_s5_v || i_err_ready;
    assign en4 = !r_s4_v || en5;
    assign en3 = !r_s3_v || en4;
    assign en2 = !r_s2_v || en3;
    assign en1 = !r_s1_v || en2;

    assign o_in_ready  = en1;
    assign o_err_valid = r_s5_v;
    assign o_err_item  = r_s5_item;

    // quotient estimate, floor of angle over one turn, within one
    always_comb begin
        prod_d  = PROD_W'($signed(r_s1_req.desired_angle)) * PROD_W'(RECIP_S);
        prod_m  = PROD_W'($signed(r_s1_req.measured_angle)) * PROD_W'(RECIP_S);
        n_s2_qd = $signed(prod_d[PROD_W-1:RECIP_SH]);
        n_s2_qm = $signed(prod_m[PROD_W-1:RECIP_SH]);
    end

    // raw remainder, in [-turn, 2 turn)
    always_comb begin
        mod_d    = MODX_W'(r_s2_des) - MODX_W'(r_s2_qd) * TURN_M;
        mod_m    = MODX_W'(r_s2_meas) - MODX_W'(r_s2_qm) * TURN_M;
        n_s3_rrd = $signed(mod_d[RR_W-1:0]);
        n_s3_rrm = $signed(mod_m[RR_W-1:0]);
    end

    // remainders into [0, turn), desired wrapped to within half a turn
    always_comb begin
        rd_fix  = mod_fix(r_s3_rrd);
        n_s4_rm = mod_fix(r_s3_rrm);
        if ((rd_fix + rd_fix) < TURN_R) begin
            n_s4_s = rd_fix;
        end else begin
            n_s4_s = rd_fix - TURN_R;
        end
    end

    // floor copy unless the ceiling copy is at least as close
    always_comb begin
        s_x  = ERR_X_W'(r_s4_s);
        rm_x = ERR_X_W'(r_s4_rm);
        d_x  = s_x - rm_x;
        if (r_s4_rm == '0) begin
            e_x = s_x;
        end else if ((d_x + d_x + TURN_E) > 0) begin
            e_x = d_x;
        end else begin
            e_x = d_x + TURN_E;
        end
        n_s5_err = sat_ang(SAT_W'(e_x));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_in_valid;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
            if (en4) r_s4_v <= r_s3_v;
            if (en5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_req <= i_in_req;
        end
        if (en2) begin
            r_s2_ctrl <= '{joint: r_s1_req.joint, restart: r_s1_req.restart,
                           at_end: r_s1_req.at_end};
            r_s2_des  <= r_s1_req.desired_angle;
            r_s2_meas <= r_s1_req.measured_angle;
            r_s2_qd   <= n_s2_qd;
            r_s2_qm   <= n_s2_qm;
        end
        if (en3) begin
            r_s3_ctrl <= r_s2_ctrl;
            r_s3_rrd  <= n_s3_rrd;
            r_s3_rrm  <= n_s3_rrm;
        end
        if (en4) begin
            r_s4_ctrl <= r_s3_ctrl;
            r_s4_s    <= n_s4_s;
            r_s4_rm   <= n_s4_rm;
        end
        if (en5) begin
            r_s5_item.ctrl <= r_s4_ctrl;
            r_s5_item.err  <= n_s5_err;
        end
    end

    a_quot_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> ((r_s3_rrd >= -TURN_R) && (r_s3_rrd < TURN2_R)
                    && (r_s3_rrm >= -TURN_R) && (r_s3_rrm < TURN2_R)))
        else $error("quotient estimate off by more than one");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> ((r_s4_rm >= 0) && (r_s4_rm < TURN_R)))
        else $error("measured remainder outside one turn");

    a_err_half_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_v |-> ((r_s5_item.err <= ERR_BND) && (r_s5_item.err >= -ERR_BND)))
        else $error("position error beyond half a turn");

endmodule

FILE: src/joint_pd_velocity_command_top.sv
// ----------------------------------------------------------------------------
// joint_pd_velocity_command_top
// Per-joint pd velocity drive with angle wrap, drive limit warning and
// set completion check over the summed absolute errors.
// ----------------------------------------------------------------------------
// throughput: one request per cycle, limited by nothing but output stalls
// the per-joint previous error is read and written in one stage, so
// requests for the same joint follow back to back without hazard
// reset: clears pipeline valids, previous errors, error sum; gains to zero,
// drive limit to 50.0 and finish tolerance to 0.03 rad
module joint_pd_velocity_command_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  jpvc_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output jpvc_pkg::t_out_res                 o_out_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jpvc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jpvc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import jpvc_pkg::*;

    localparam logic [SUM_W:0]          SUM_MAX = {1'b0, {SUM_W{1'b1}}};
    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(longint'(1) << (DRV_SH - 1));

    logic [GAIN_W-1:0] r_prop_gain, r_deriv_gain;
    logic [LIM_W-1:0]  r_drive_limit, r_finish_tol;

    logic      e_valid, e_ready;
    t_err_item e_item;

    logic signed [ANG_W-1:0] r_prev [JOINT_COUNT];
    logic [SUM_W-1:0]        r_sum;

    logic en6, en7, en8, en_out;
    logic r_s6_v, r_s7_v, r_s8_v, r_out_valid;

    logic [JOINT_X_W-1:0]    jx;
    logic [JIDX_W-1:0]       idx;
    logic                    j_ok, j_last;
    logic signed [ANG_W-1:0] prev;
    logic signed [ANG_W:0]   err_x;
    logic [ANG_W-1:0]        abs_err;
    logic [SUM_W-1:0]        sum_base, n_s6_sum;
    logic [SUM_W:0]          sum_x;

    logic [JOINT_W-1:0]       r_s6_joint, r_s7_joint, r_s8_joint;
    logic signed [ANG_W-1:0]  r_s6_err, r_s7_err, r_s8_err;
    logic signed [DIFF_W-1:0] r_s6_diff, n_s6_diff;
    logic [SUM_W-1:0]         r_s6_sum;
    logic                     r_s6_chk, n_s6_chk;
    logic                     r_s7_done, r_s8_done, n_s7_done;
    logic signed [PP_W-1:0]   r_s7_pp, n_s7_pp;
    logic signed [PD_W-1:0]   r_s7_pd, n_s7_pd;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SHF_W-1:0]  r_s8_shf, n_s8_shf;

    logic signed [NEG_W-1:0] shf_x, drv_x;
    logic signed [ANG_W:0]   dx, limx;
    t_out_res                r_out_res, n_out_res;

    jpvc_err_pipe u_err_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_err_valid (e_valid),
        .i_err_ready (e_ready),
        .o_err_item  (e_item)
    );

    assign en_out  = !r_out_valid || i_out_ready;
    assign en8     = !r_s8_v || en_out;
    assign en7     = !r_s7_v || en8;
    assign en6     = !r_s6_v || en7;
    assign e_ready = en6;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_deriv_gain  <= '0;
            r_drive_limit <= DRIVE_LIMIT_RST;
            r_finish_tol  <= FINISH_TOL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[LIM_W-1:0];
                CFG_FINISH_TOL:  r_finish_tol  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // joint state: previous error lookup, error sum
    always_comb begin
        jx     = JOINT_X_W'(e_item.ctrl.joint);
        idx    = jx[JIDX_W-1:0];
        j_ok   = jx < JOINT_X_W'(JOINT_COUNT);
        j_last = jx == JOINT_X_W'(JOINT_COUNT - 1);
        if (e_item.ctrl.restart || !j_ok) begin
            prev = '0;
        end else begin
            prev = r_prev[idx];
        end
        n_s6_diff = DIFF_W'(e_item.err) - DIFF_W'(prev);
        err_x     = (ANG_W + 1)'(e_item.err);
        if (err_x < 0) begin
            err_x = -err_x;
        end
        abs_err  = err_x[ANG_W-1:0];
        sum_base = e_item.ctrl.restart ? '0 : r_sum;
        sum_x    = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(abs_err);
        n_s6_sum = (sum_x > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_x[SUM_W-1:0];
        n_s6_chk = j_ok && j_last && e_item.ctrl.at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                r_prev[j] <= '0;
            end
            r_sum <= '0;
        end else if (e_valid && en6) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                if (j_ok && (idx == JIDX_W'(j))) begin
                    r_prev[j] <= e_item.err;
                end else if (e_item.ctrl.restart) begin
                    r_prev[j] <= '0;
                end
            end
            if (j_ok) begin
                r_sum <= j_last ? '0 : n_s6_sum;
            end else if (e_item.ctrl.restart) begin
                r_sum <= '0;
            end
        end
    end

    // gain products and done check
    always_comb begin
        n_s7_pp   = PP_W'($signed({1'b0, r_prop_gain})) * PP_W'(r_s6_err);
        n_s7_pd   = PD_W'($signed({1'b0, r_deriv_gain})) * PD_W'(r_s6_diff);
        n_s7_done = r_s6_chk && (r_s6_sum < SUM_W'(r_finish_tol));
    end

    // sum and round half up to q15.8
    always_comb begin
        acc      = ACC_W'(r_s7_pp) + ACC_W'(r_s7_pd) + ROUND_C;
        n_s8_shf = $signed(acc[ACC_W-1:DRV_SH]);
    end

    // sign per joint, saturate, limit check
    always_comb begin
        shf_x = NEG_W'(r_s8_shf);
        drv_x = (r_s8_joint != POS_JOINT) ? -shf_x : shf_x;
        n_out_res.joint_out   = r_s8_joint;
        n_out_res.drive       = sat_ang(SAT_W'(drv_x));
        n_out_res.joint_error = r_s8_err;
        n_out_res.done_res    = r_s8_done;
        dx   = (ANG_W + 1)'(n_out_res.drive);
        limx = $signed((ANG_W + 1)'(r_drive_limit));
        n_out_res.over_limit = (dx > limx) || (dx < -limx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v      <= 1'b0;
            r_s7_v      <= 1'b0;
            r_s8_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en6)    r_s6_v      <= e_valid;
            if (en7)    r_s7_v      <= r_s6_v;
            if (en8)    r_s8_v      <= r_s7_v;
            if (en_out) r_out_valid <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_s6_joint <= e_item.ctrl.joint;
            r_s6_err   <= e_item.err;
            r_s6_diff  <= n_s6_diff;
            r_s6_sum   <= n_s6_sum;
            r_s6_chk   <= n_s6_chk;
        end
        if (en7) begin
            r_s7_joint <= r_s6_joint;
            r_s7_err   <= r_s6_err;
            r_s7_pp    <= n_s7_pp;
            r_s7_pd    <= n_s7_pd;
            r_s7_done  <= n_s7_done;
        end
        if (en8) begin
            r_s8_joint <= r_s7_joint;
            r_s8_err   <= r_s7_err;
            r_s8_shf   <= n_s8_shf;
            r_s8_done  <= r_s7_done;
        end
        if (en_out) begin
            r_out_res <= n_out_res;
        end
    end

    a_done_last_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.done_res)
            |-> (r_out_res.joint_out == JOINT_W'(JOINT_COUNT - 1)))
        else $error("done raised on a joint other than the last");

    a_sum_cleared_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_valid && en6 && j_ok && j_last) |=> (r_sum == '0))
        else $error("error sum not cleared after last joint");

    a_restart_clears_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_valid && en6 && e_item.ctrl.restart && !j_ok) |=> (r_sum == '0))
        else $error("restart did not clear error sum");

endmodule
